>>> sv/timed_button_qualifier_unit_defines.svh
// assertion helpers for the timed button qualifier
`ifndef TIMED_BUTTON_QUALIFIER_UNIT_DEFINES_SVH
`define TIMED_BUTTON_QUALIFIER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// checked property, disabled while reset is asserted
`define TBQ_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked property, active through reset as well
`define TBQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TBQ_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define TBQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> sv/tbq_pkg.sv
package tbq_pkg;

  // default accumulator width in bits
  localparam int TIME_BITS_DEF = 26;

  // configuration register indexes
  localparam logic [2:0] CFG_BUTTON_MODE   = 3'd0;
  localparam logic [2:0] CFG_TIMER_MODE    = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_ACT_DEPTH     = 3'd3;
  localparam logic [2:0] CFG_DEACT_DEPTH   = 3'd4;
  localparam logic [2:0] CFG_EXEC_DELAY    = 3'd5;
  localparam logic [2:0] CFG_ON_DURATION   = 3'd6;

  // button modes
  localparam logic [1:0] BM_TOGGLE    = 2'd0;
  localparam logic [1:0] BM_MOMENTARY = 2'd1;
  localparam logic [1:0] BM_TIMER     = 2'd2;

  // timer sub-modes
  localparam logic [1:0] TM_HOLD     = 2'd0;
  localparam logic [1:0] TM_PRESS    = 2'd1;
  localparam logic [1:0] TM_RELEASE  = 2'd2;

  // register reset values
  localparam logic signed [15:0] ACT_DEPTH_RST   = 16'sd64;
  localparam logic signed [15:0] DEACT_DEPTH_RST = 16'sd32;
  localparam logic [23:0]        ON_DURATION_RST = 24'd1000000;

  typedef struct packed {
    logic [1:0]         button_mode;
    logic [1:0]         timer_mode;
    logic signed [15:0] origin_height;
    logic signed [15:0] activation_depth;
    logic signed [15:0] deactivation_depth;
    logic [23:0]        execute_delay;
    logic [23:0]        on_duration;
  } cfg_t;

  typedef struct packed {
    logic pressed;
    logic power_state;
    logic power_on_event;
    logic power_off_event;
    logic fasten_request;
  } res_t;

endpackage

>>> sv/timed_button_qualifier_unit.sv
// Timed button qualifier. Each input beat carries a plunger height (signed
// 8.8) and the microseconds since the previous beat; each produces exactly one
// result beat with the hysteresis-qualified pressed flag, the power output,
// on/off events and a fasten request. One beat is accepted per clock unless
// the input stalls: a beat is held in the input register, then the mode
// logic and both saturating time accumulators resolve in one pass into the
// result register. The input stalls only while both registers are full and
// the result is stalled. The user must write configuration through
// cfg_wr_en, cfg_index and cfg_wdata only while no beat is in flight; the
// block itself does not enforce it.
`include "timed_button_qualifier_unit_defines.svh"

module timed_button_qualifier_unit #(
  parameter int TIME_BITS = tbq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_plunger_height,
  input  logic [15:0] in_tick_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_pressed,
  output logic        out_power_state,
  output logic        out_power_on_event,
  output logic        out_power_off_event,
  output logic        out_fasten_request
);
  import tbq_pkg::*;

  cfg_t                 cfg_r;
  logic                 s1_valid_r;
  logic signed [15:0]   s1_height_r;
  logic [15:0]          s1_dt_r;
  logic                 out_valid_r;
  res_t                 out_res_r;
  logic                 down_r;
  logic                 power_r;
  logic [TIME_BITS-1:0] press_r;
  logic [TIME_BITS-1:0] powt_r;
  logic                 down_nxt;
  logic                 power_nxt;
  logic [TIME_BITS-1:0] press_nxt;
  logic [TIME_BITS-1:0] powt_nxt;
  res_t                 res_nxt;
  logic                 advance;
  logic                 in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_mode        <= BM_TOGGLE;
      cfg_r.timer_mode         <= TM_HOLD;
      cfg_r.origin_height      <= '0;
      cfg_r.activation_depth   <= ACT_DEPTH_RST;
      cfg_r.deactivation_depth <= DEACT_DEPTH_RST;
      cfg_r.execute_delay      <= '0;
      cfg_r.on_duration        <= ON_DURATION_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BUTTON_MODE:   cfg_r.button_mode        <= cfg_wdata[1:0];
        CFG_TIMER_MODE:    cfg_r.timer_mode         <= cfg_wdata[1:0];
        CFG_ORIGIN_HEIGHT: cfg_r.origin_height      <= cfg_wdata[15:0];
        CFG_ACT_DEPTH:     cfg_r.activation_depth   <= cfg_wdata[15:0];
        CFG_DEACT_DEPTH:   cfg_r.deactivation_depth <= cfg_wdata[15:0];
        CFG_EXEC_DELAY:    cfg_r.execute_delay      <= cfg_wdata;
        CFG_ON_DURATION:   cfg_r.on_duration        <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // handshake: stage 1 moves on when the result register is empty or not stalled
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_height_r <= in_plunger_height;
      s1_dt_r     <= in_tick_time;
    end
  end

  tbq_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .cfg            (cfg_r),
    .plunger_height (s1_height_r),
    .tick_time      (s1_dt_r),
    .down_cur       (down_r),
    .power_cur      (power_r),
    .press_cur      (press_r),
    .powt_cur       (powt_r),
    .down_nxt       (down_nxt),
    .power_nxt      (power_nxt),
    .press_nxt      (press_nxt),
    .powt_nxt       (powt_nxt),
    .res            (res_nxt)
  );

  // button state and accumulators
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      down_r  <= 1'b0;
      power_r <= 1'b0;
      press_r <= '0;
      powt_r  <= '0;
    end else if (advance) begin
      down_r  <= down_nxt;
      power_r <= power_nxt;
      press_r <= press_nxt;
      powt_r  <= powt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pressed         = out_res_r.pressed;
  assign out_power_state     = out_res_r.power_state;
  assign out_power_on_event  = out_res_r.power_on_event;
  assign out_power_off_event = out_res_r.power_off_event;
  assign out_fasten_request  = out_res_r.fasten_request;

  // off event without a new on leaves power off
  `TBQ_ASSERT_RST(a_off_event_state, clk, rst_n, out_valid_r && out_res_r.power_off_event && !out_res_r.power_on_event |-> !out_res_r.power_state, "off event with power still on")
  // any on event leaves power on
  `TBQ_ASSERT_RST(a_on_event_state, clk, rst_n, out_valid_r && out_res_r.power_on_event |-> out_res_r.power_state, "on event with power off")
  // fasten only with power on and no off event
  `TBQ_ASSERT_RST(a_fasten_power, clk, rst_n, out_valid_r && out_res_r.fasten_request |-> out_res_r.power_state && !out_res_r.power_off_event, "fasten without power")
  // stall only when stage 1 is full
  `TBQ_ASSERT_RST(a_stall_full, clk, rst_n, in_stall |-> s1_valid_r && out_valid_r && out_stall, "input stalled with room")
  // state mirrors the last delivered beat
  `TBQ_ASSERT_RST(a_state_mirror, clk, rst_n, $past(advance) && rst_n && $past(rst_n) |-> down_r == out_res_r.pressed && power_r == out_res_r.power_state, "state and result differ")
  // nothing valid after reset
  `TBQ_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid_r && !s1_valid_r, "valid after reset")

endmodule

>>> sv/tbq_core.sv
module tbq_core #(
  parameter int TIME_BITS = tbq_pkg::TIME_BITS_DEF
) (
  input  tbq_pkg::cfg_t        cfg,
  input  logic signed [15:0]   plunger_height,
  input  logic [15:0]          tick_time,
  input  logic                 down_cur,
  input  logic                 power_cur,
  input  logic [TIME_BITS-1:0] press_cur,
  input  logic [TIME_BITS-1:0] powt_cur,
  output logic                 down_nxt,
  output logic                 power_nxt,
  output logic [TIME_BITS-1:0] press_nxt,
  output logic [TIME_BITS-1:0] powt_nxt,
  output tbq_pkg::res_t        res
);
  import tbq_pkg::*;

  // compare width covers the accumulators and the 25-bit hold threshold
  localparam int CW = ((TIME_BITS > 25) ? TIME_BITS : 25) + 1;

  logic signed [16:0]   depth;
  logic signed [16:0]   act_ext;
  logic signed [16:0]   deact_ext;
  logic [TIME_BITS:0]   press_sum;
  logic [TIME_BITS:0]   powt_sum;
  logic [TIME_BITS-1:0] press_acc;
  logic [TIME_BITS-1:0] press_fresh;
  logic [TIME_BITS-1:0] powt_acc;
  logic [24:0]          hold_thr;
  logic                 ge_acc;
  logic                 ge_fresh;
  logic                 ge_old;
  logic                 ge_zero;
  logic                 ge_hold;
  logic                 powt_done;
  logic                 timed_out;
  logic                 base_ge;
  logic [TIME_BITS-1:0] press_base;
  logic                 ev_on;
  logic                 ev_off;
  logic                 fasten;

  // press depth, 17-bit signed 9.8
  assign depth     = {cfg.origin_height[15], cfg.origin_height}
                   - {plunger_height[15], plunger_height};
  assign act_ext   = {cfg.activation_depth[15], cfg.activation_depth};
  assign deact_ext = {cfg.deactivation_depth[15], cfg.deactivation_depth};

  // saturating accumulators
  assign press_sum   = {1'b0, press_cur} + (TIME_BITS+1)'(tick_time);
  assign powt_sum    = {1'b0, powt_cur} + (TIME_BITS+1)'(tick_time);
  assign press_acc   = press_sum[TIME_BITS] ? '1 : press_sum[TIME_BITS-1:0];
  assign powt_acc    = powt_sum[TIME_BITS] ? '1 : powt_sum[TIME_BITS-1:0];
  assign press_fresh = TIME_BITS'(tick_time);
  assign hold_thr    = {1'b0, cfg.on_duration} + {1'b0, cfg.execute_delay};

  // threshold compares, all in parallel
  assign ge_acc    = CW'(press_acc) >= CW'(cfg.execute_delay);
  assign ge_fresh  = CW'(press_fresh) >= CW'(cfg.execute_delay);
  assign ge_old    = CW'(press_cur) >= CW'(cfg.execute_delay);
  assign ge_zero   = (cfg.execute_delay == '0);
  assign ge_hold   = CW'(press_acc) >= CW'(hold_thr);
  assign powt_done = CW'(powt_acc) >= CW'(cfg.on_duration);

  // timeout in the pulse modes restarts the press count from zero
  assign timed_out  = power_cur && powt_done;
  assign press_base = timed_out ? press_fresh : press_acc;
  assign base_ge    = timed_out ? ge_fresh : ge_acc;

  // next state and events
  always_comb begin
    down_nxt  = down_cur;
    power_nxt = power_cur;
    press_nxt = press_cur;
    powt_nxt  = powt_cur;
    ev_on     = 1'b0;
    ev_off    = 1'b0;
    fasten    = 1'b0;

    if (depth >= act_ext) begin
      down_nxt = 1'b1;
    end else if (depth <= deact_ext) begin
      down_nxt = 1'b0;
    end

    case (cfg.button_mode)
      BM_TOGGLE, BM_MOMENTARY: begin
        if (down_nxt) begin
          press_nxt = press_acc;
          if (ge_acc) begin
            if (!power_cur) begin
              power_nxt = 1'b1;
              powt_nxt  = '0;
              ev_on     = 1'b1;
            end
            fasten = (cfg.button_mode == BM_TOGGLE);
          end
        end else begin
          if (cfg.button_mode == BM_MOMENTARY && power_cur) begin
            power_nxt = 1'b0;
            ev_off    = 1'b1;
          end
          press_nxt = '0;
        end
      end
      BM_TIMER: begin
        case (cfg.timer_mode)
          TM_HOLD: begin
            if (down_nxt) begin
              press_nxt = press_acc;
              if (ge_hold && !power_cur) begin
                power_nxt = 1'b1;
                powt_nxt  = '0;
                ev_on     = 1'b1;
              end
            end else begin
              press_nxt = '0;
            end
          end
          TM_PRESS, TM_RELEASE: begin
            // power timeout first
            if (timed_out) begin
              power_nxt = 1'b0;
              powt_nxt  = '0;
              ev_off    = 1'b1;
            end else if (power_cur) begin
              powt_nxt = powt_acc;
            end
            if (cfg.timer_mode == TM_PRESS) begin
              if (down_nxt) begin
                press_nxt = press_base;
                if (base_ge) begin
                  if (!power_nxt) begin
                    ev_on = 1'b1;
                  end
                  power_nxt = 1'b1;
                  powt_nxt  = '0;
                end
              end else begin
                press_nxt = '0;
              end
            end else begin
              if (down_nxt) begin
                press_nxt = press_base;
              end else begin
                if (timed_out ? ge_zero : ge_old) begin
                  if (!power_nxt) begin
                    ev_on = 1'b1;
                  end
                  power_nxt = 1'b1;
                  powt_nxt  = '0;
                end
                press_nxt = '0;
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign res.pressed         = down_nxt;
  assign res.power_state     = power_nxt;
  assign res.power_on_event  = ev_on;
  assign res.power_off_event = ev_off;
  assign res.fasten_request  = fasten;

endmodule

>>> bench/timed_button_qualifier_unit_test.sv
module timed_button_qualifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tbq_pkg::*;

  localparam int TB_TIME_BITS = TIME_BITS_DEF;
  localparam longint unsigned TIME_CAP = (64'd1 << TB_TIME_BITS) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_BEATS = 100;
  localparam int MAX_SHOWN = 40;
  // mode code with no behavior of its own, for button and timer mode alike
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [15:0] height;
    logic [15:0]        dt;
  } tick_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = CFG_BUTTON_MODE;
  logic [23:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_plunger_height = '0;
  logic [15:0]        in_tick_time = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_pressed;
  logic               out_power_state;
  logic               out_power_on_event;
  logic               out_power_off_event;
  logic               out_fasten_request;

  timed_button_qualifier_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_plunger_height   (in_plunger_height),
    .in_tick_time        (in_tick_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_pressed         (out_pressed),
    .out_power_state     (out_power_state),
    .out_power_on_event  (out_power_on_event),
    .out_power_off_event (out_power_off_event),
    .out_fasten_request  (out_fasten_request)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // qualifier state as the testbench tracks it
  cfg_t                    cur_cfg;
  logic                    mdl_down = 1'b0;
  logic                    mdl_power = 1'b0;
  logic [TB_TIME_BITS-1:0] mdl_press_us = '0;
  logic [TB_TIME_BITS-1:0] mdl_power_us = '0;
  logic                    ev_on;
  logic                    ev_off;

  tick_t ticks_to_send[$];
  res_t  predicted_flags[$];
  tick_t nxt;
  res_t  exp_res;

  int total_pushed = 0;
  int results_seen = 0;
  int beats_in = 0;
  int err_count = 0;
  int random_items = 0;
  int settings_used = 0;
  int on_seen = 0;
  int off_seen = 0;
  int fasten_seen = 0;
  int both_seen = 0;
  int cycle_cnt = 0;

  function automatic cfg_t base_setup();
    cfg_t c;
    c.button_mode        = BM_TOGGLE;
    c.timer_mode         = TM_HOLD;
    c.origin_height      = '0;
    c.activation_depth   = ACT_DEPTH_RST;
    c.deactivation_depth = DEACT_DEPTH_RST;
    c.execute_delay      = '0;
    c.on_duration        = ON_DURATION_RST;
    return c;
  endfunction

  initial cur_cfg = base_setup();

  // saturating microsecond accumulator
  function automatic logic [TB_TIME_BITS-1:0] add_capped(logic [TB_TIME_BITS-1:0] acc,
                                                          logic [15:0] dt);
    longint unsigned s;
    s = acc;
    s = s + dt;
    if (s > TIME_CAP) s = TIME_CAP;
    return s[TB_TIME_BITS-1:0];
  endfunction

  function automatic void power_up();
    if (!mdl_power) begin
      mdl_power = 1'b1;
      mdl_power_us = '0;
      ev_on = 1'b1;
    end
  endfunction

  function automatic void power_down();
    if (mdl_power) begin
      mdl_power = 1'b0;
      ev_off = 1'b1;
    end
  endfunction

  // pulse modes: running power times out first
  function automatic void pulse_expiry(logic [15:0] dt);
    if (mdl_power) begin
      mdl_power_us = add_capped(mdl_power_us, dt);
      if (mdl_power_us >= cur_cfg.on_duration) begin
        power_down();
        mdl_press_us = '0;
        mdl_power_us = '0;
      end
    end
  endfunction

  // one tick through hysteresis and mode logic
  function automatic res_t qualify_tick(logic signed [15:0] height, logic [15:0] dt);
    int depth;
    longint unsigned hold_need;
    logic fasten;
    res_t r;
    depth = $signed(cur_cfg.origin_height) - $signed(height);
    fasten = 1'b0;
    ev_on = 1'b0;
    ev_off = 1'b0;

    // activation test wins when both thresholds hold
    if (depth >= $signed(cur_cfg.activation_depth)) mdl_down = 1'b1;
    else if (depth <= $signed(cur_cfg.deactivation_depth)) mdl_down = 1'b0;

    case (cur_cfg.button_mode)
      BM_TOGGLE, BM_MOMENTARY: begin
        if (mdl_down) begin
          mdl_press_us = add_capped(mdl_press_us, dt);
          if (mdl_press_us >= cur_cfg.execute_delay) begin
            power_up();
            fasten = (cur_cfg.button_mode == BM_TOGGLE);
          end
        end else begin
          if (cur_cfg.button_mode == BM_MOMENTARY) power_down();
          mdl_press_us = '0;
        end
      end
      BM_TIMER: begin
        case (cur_cfg.timer_mode)
          TM_HOLD: begin
            if (mdl_down) begin
              mdl_press_us = add_capped(mdl_press_us, dt);
              hold_need = cur_cfg.on_duration;
              hold_need += cur_cfg.execute_delay;
              if (mdl_press_us >= hold_need) power_up();
            end else begin
              mdl_press_us = '0;
            end
          end
          TM_PRESS: begin
            pulse_expiry(dt);
            if (mdl_down) begin
              mdl_press_us = add_capped(mdl_press_us, dt);
              if (mdl_press_us >= cur_cfg.execute_delay) begin
                power_up();
                mdl_power_us = '0;
              end
            end else begin
              mdl_press_us = '0;
            end
          end
          TM_RELEASE: begin
            pulse_expiry(dt);
            if (mdl_down) begin
              mdl_press_us = add_capped(mdl_press_us, dt);
            end else begin
              if (mdl_press_us >= cur_cfg.execute_delay) begin
                power_up();
                mdl_power_us = '0;
              end
              mdl_press_us = '0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    r.pressed         = mdl_down;
    r.power_state     = mdl_power;
    r.power_on_event  = ev_on;
    r.power_off_event = ev_off;
    r.fasten_request  = fasten;
    return r;
  endfunction

  // register write, lands at the next rising edge
  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    while (results_seen != total_pushed) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // drain, then load a full register set
  task automatic apply_setup(cfg_t c);
    wait_idle();
    @(posedge clk);
    write_reg(CFG_BUTTON_MODE, {22'd0, c.button_mode});
    write_reg(CFG_TIMER_MODE, {22'd0, c.timer_mode});
    write_reg(CFG_ORIGIN_HEIGHT, {8'd0, c.origin_height});
    write_reg(CFG_ACT_DEPTH, {8'd0, c.activation_depth});
    write_reg(CFG_DEACT_DEPTH, {8'd0, c.deactivation_depth});
    write_reg(CFG_EXEC_DELAY, c.execute_delay);
    write_reg(CFG_ON_DURATION, c.on_duration);
    cfg_wr_en <= 1'b0;
    cur_cfg = c;
    settings_used++;
    @(negedge clk);
  endtask

  task automatic queue_tick(logic signed [15:0] h, logic [15:0] dt);
    tick_t t;
    t.height = h;
    t.dt = dt;
    ticks_to_send.push_back(t);
    total_pushed++;
  endtask

  // plunger height giving the wanted depth, clamped to the field
  function automatic logic signed [15:0] height_for(int depth);
    int h;
    h = $signed(cur_cfg.origin_height) - depth;
    if (h > 32767) h = 32767;
    else if (h < -32768) h = -32768;
    return h[15:0];
  endfunction

  function automatic logic [15:0] rand_dt();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 16'd0;
    if (pick == 1) return 16'hFFFF;
    if (pick < 6) return 16'($urandom_range(0, 20000));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic cfg_t random_setup();
    cfg_t c;
    int pick, act, deact;
    c = base_setup();
    pick = $urandom_range(0, 19);
    if (pick < 5) c.button_mode = BM_TOGGLE;
    else if (pick < 9) c.button_mode = BM_MOMENTARY;
    else if (pick < 19) c.button_mode = BM_TIMER;
    else c.button_mode = MODE_UNUSED;

    pick = $urandom_range(0, 12);
    if (pick < 4) c.timer_mode = TM_HOLD;
    else if (pick < 8) c.timer_mode = TM_PRESS;
    else if (pick < 12) c.timer_mode = TM_RELEASE;
    else c.timer_mode = MODE_UNUSED;

    pick = $urandom_range(0, 7);
    if (pick == 0) c.origin_height = 16'sh7FFF;
    else if (pick == 1) c.origin_height = 16'sh8000;
    else c.origin_height = 16'(int'($urandom_range(0, 16000)) - 8000);

    // thresholds: usual band, equal, inverted, extremes
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      act = $urandom_range(1, 3000);
      deact = act - int'($urandom_range(0, 1500));
    end else if (pick == 7) begin
      act = $urandom_range(1, 3000);
      deact = act + int'($urandom_range(1, 1000));
    end else if (pick == 8) begin
      act = -32768;
      deact = 32767;
    end else begin
      act = 32767;
      deact = -32768;
    end
    c.activation_depth = 16'(act);
    c.deactivation_depth = 16'(deact);

    pick = $urandom_range(0, 19);
    if (pick < 5) c.execute_delay = '0;
    else if (pick < 15) c.execute_delay = 24'($urandom_range(0, 100000));
    else if (pick < 19) c.execute_delay = 24'($urandom_range(0, 400000));
    else c.execute_delay = 24'hFFFFFF;

    pick = $urandom_range(0, 19);
    if (pick < 3) c.on_duration = '0;
    else if (pick < 13) c.on_duration = 24'($urandom_range(0, 100000));
    else if (pick < 19) c.on_duration = 24'($urandom_range(0, 400000));
    else c.on_duration = 24'hFFFFFF;
    return c;
  endfunction

  // mostly press/release strokes, some mid-band dwell and raw noise
  task automatic queue_random_phase(int n);
    int made, len, act, deact, pick;
    act = $signed(cur_cfg.activation_depth);
    deact = $signed(cur_cfg.deactivation_depth);
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = $urandom_range(1, 12);
        repeat (len) begin
          queue_tick(height_for(act + int'($urandom_range(0, 300))), rand_dt());
          made++;
        end
        len = $urandom_range(1, 6);
        repeat (len) begin
          queue_tick(height_for(deact - int'($urandom_range(0, 300))), rand_dt());
          made++;
        end
      end else if (pick == 7 && act - deact > 1) begin
        len = $urandom_range(1, 4);
        repeat (len) begin
          queue_tick(height_for(deact + 1 + int'($urandom_range(0, act - deact - 2))),
                     rand_dt());
          made++;
        end
      end else begin
        queue_tick(16'($urandom), 16'($urandom));
        made++;
      end
    end
    random_items += made;
  endtask

  // stimulus
  initial begin
    cfg_t c;
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // toggle: threshold edges, mid band, extreme heights and tick times
    c = base_setup();
    c.execute_delay = 24'd100;
    apply_setup(c);
    queue_tick(0, 0);
    queue_tick(-64, 50);
    queue_tick(-64, 50);
    queue_tick(-48, 16'hFFFF);
    queue_tick(-32, 7);
    queue_tick(32767, 0);
    queue_tick(-32768, 16'hFFFF);

    // momentary: release drops power, press with no delay
    c = base_setup();
    c.button_mode = BM_MOMENTARY;
    apply_setup(c);
    queue_tick(0, 10);
    queue_tick(-100, 0);
    queue_tick(-40, 5);
    queue_tick(0, 1);

    // timed hold needs delay plus duration
    c = base_setup();
    c.button_mode = BM_TIMER;
    c.timer_mode = TM_HOLD;
    c.execute_delay = 24'd500;
    c.on_duration = 24'd1000;
    apply_setup(c);
    queue_tick(-70, 1000);
    queue_tick(-70, 499);
    queue_tick(-70, 1);
    queue_tick(0, 3);

    // pulse on press with zero duration: off and on in one tick
    c.timer_mode = TM_PRESS;
    c.execute_delay = '0;
    c.on_duration = '0;
    apply_setup(c);
    queue_tick(-80, 5);
    queue_tick(0, 0);

    // pulse on release and its timeout
    c.timer_mode = TM_RELEASE;
    c.execute_delay = 24'd10;
    c.on_duration = 24'd100;
    apply_setup(c);
    queue_tick(-80, 20);
    queue_tick(0, 30);
    queue_tick(0, 60);
    queue_tick(0, 40);

    // unused button mode only tracks the button
    c.button_mode = MODE_UNUSED;
    apply_setup(c);
    queue_tick(-80, 9);
    queue_tick(0, 9);

    // unused timer mode, extreme origin and inverted extreme thresholds
    c.button_mode = BM_TIMER;
    c.timer_mode = MODE_UNUSED;
    c.origin_height = 16'sh8000;
    c.activation_depth = 16'sh8000;
    c.deactivation_depth = 16'sh7FFF;
    apply_setup(c);
    queue_tick(32767, 16'hFFFF);
    queue_tick(-32768, 0);

    c = base_setup();
    c.button_mode = BM_MOMENTARY;
    c.origin_height = 16'sh7FFF;
    c.activation_depth = 16'sh7FFF;
    c.deactivation_depth = 16'sh8000;
    apply_setup(c);
    queue_tick(-32768, 1);
    queue_tick(32767, 1);

    // long press runs the accumulator into saturation, fasten must stay up
    c = base_setup();
    c.execute_delay = 24'hFFFFFF;
    c.on_duration = 24'hFFFFFF;
    apply_setup(c);
    queue_tick(0, 0);
    for (i = 0; i < 1040; i++) queue_tick(-200, 16'($urandom_range(65000, 65535)));
    queue_tick(0, 1);

    // random settings with random strokes
    while (random_items < RANDOM_BEATS) begin
      apply_setup(random_setup());
      queue_random_phase($urandom_range(20, 80));
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (predicted_flags.size() != 0) begin
      err_count++;
      $display("%0t: %0d predicted results never arrived", $time, predicted_flags.size());
    end
    $display("%0d beats over %0d register settings, all button and timer modes, %s",
             beats_in, settings_used, "threshold and delay extremes, accumulator saturation");
    $display("events: %0d power on, %0d power off, %0d both in one tick, %0d fasten",
             on_seen, off_seen, both_seen, fasten_seen);
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // input driver: bursts with random gaps, payload held while stalled
  int gap_left = 0;
  int burst_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_flags.push_back(qualify_tick(in_plunger_height, in_tick_time));
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ticks_to_send.size() != 0) begin
          nxt = ticks_to_send.pop_front();
          in_valid <= 1'b1;
          in_plunger_height <= nxt.height;
          in_tick_time <= nxt.dt;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall pattern, with one long hold-off to back up the input
  int  hold_left = 0;
  int  stall_run = 0;
  int  stall_kind = 0;
  bit  long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && beats_in >= 200) begin
      long_hold_done = 1'b1;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      if (stall_run == 0) begin
        stall_kind = $urandom_range(0, 2);
        stall_run = $urandom_range(10, 150);
      end else begin
        stall_run--;
      end
      case (stall_kind)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  function automatic void check_bit(string name, logic exp, logic act);
    if (act !== exp) begin
      err_count++;
      if (err_count <= MAX_SHOWN)
        $display("%0t: beat %0d %s expected %b got %b", $time, results_seen, name, exp, act);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (predicted_flags.size() == 0) begin
        err_count++;
        if (err_count <= MAX_SHOWN)
          $display("%0t: result beat with nothing predicted, expected none got %b%b%b%b%b",
                   $time, out_pressed, out_power_state, out_power_on_event,
                   out_power_off_event, out_fasten_request);
      end else begin
        exp_res = predicted_flags.pop_front();
        check_bit("pressed", exp_res.pressed, out_pressed);
        check_bit("power_state", exp_res.power_state, out_power_state);
        check_bit("power_on_event", exp_res.power_on_event, out_power_on_event);
        check_bit("power_off_event", exp_res.power_off_event, out_power_off_event);
        check_bit("fasten_request", exp_res.fasten_request, out_fasten_request);
        if (exp_res.power_on_event) on_seen++;
        if (exp_res.power_off_event) off_seen++;
        if (exp_res.power_on_event && exp_res.power_off_event) both_seen++;
        if (exp_res.fasten_request) fasten_seen++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d of %0d results seen", $time, results_seen, total_pushed);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
